[rtl/rrl_pkg.sv]
// Shared types and constants of the response rate limiter.
// Holds field widths, codes, the entry layout and the controller interface.
// No dependencies.
package rrl_pkg;

    localparam int RATE_W   = 10;
    localparam int WIN_W    = 12;
    localparam int SLIP_W   = 8;
    localparam int TIME_W   = 32;
    localparam int BAL_W    = 23;
    localparam int IDX_W    = 10;
    localparam int KIND_W   = 2;
    localparam int VERD_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    // wider balance for intermediate sums and the debit
    localparam int ACC_W    = BAL_W + 1;
    // product widths
    localparam int PROD_W   = RATE_W + WIN_W;

    // response kinds
    localparam logic [KIND_W-1:0] KIND_ANSWER   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NXDOMAIN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 2'd2;

    // verdicts
    localparam logic [VERD_W-1:0] VERD_SEND = 2'd0;
    localparam logic [VERD_W-1:0] VERD_DROP = 2'd1;
    localparam logic [VERD_W-1:0] VERD_SLIP = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_ANSWERS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_NXDOMAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_ERRORS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLIP_EVERY    = 3'd4;

    // one table entry
    typedef struct packed {
        logic                    valid;
        logic signed [BAL_W-1:0] bal;
        logic [SLIP_W-1:0]       slip;
        logic [TIME_W-1:0]       stamp;
    } t_entry;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_AGE,
        S_MUL,
        S_CREDIT,
        S_COMMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_en;
        logic cap_en;
        logic mod_en;
        logic age_en;
        logic mul_en;
        logic credit_en;
        logic commit_en;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic rate_zero;
        logic out_free;
    } t_stat;

endpackage

[rtl/rrl_ctrl.sv]
// Sequencer of the response rate limiter: clearing pass, then one request
// at a time through index reduction, table read, credit and commit.
// Depends on rrl_pkg.
module rrl_ctrl
    import rrl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap_en = 1'b1;
                    n_state      = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_en = 1'b1;
                n_state      = S_READ;
            end
            S_READ: begin
                n_state = S_AGE;
            end
            S_AGE: begin
                o_cmd.age_en = 1'b1;
                // disabled rate skips the credit steps
                n_state = i_stat.rate_zero ? S_COMMIT : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_CREDIT;
            end
            S_CREDIT: begin
                o_cmd.credit_en = 1'b1;
                n_state         = S_COMMIT;
            end
            S_COMMIT: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.commit_en = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

[rtl/rrl_dpath.sv]
// Datapath of the response rate limiter: configuration registers, entry
// table, index reduction, bucket arithmetic and the output register.
// Depends on rrl_pkg; sequenced by rrl_ctrl.
module rrl_dpath
    import rrl_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [IDX_W-1:0]         i_entry_index,
    input  logic [KIND_W-1:0]        i_response_kind,
    input  logic [TIME_W-1:0]        i_now_secs,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [VERD_W-1:0]        o_verdict,
    output logic signed [BAL_W-1:0]  o_balance_after
);

    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SH      = 20;
    localparam int RCP_W   = SH + 1;
    localparam int QP_W    = IDX_W + RCP_W;
    localparam int ENT_W   = 17;
    localparam int QE_W    = IDX_W + ENT_W;
    localparam logic [RCP_W-1:0] RECIP = RCP_W'((1 << SH) / ENTRIES);
    localparam logic [ENT_W-1:0] ENT_V = ENT_W'(ENTRIES);
    localparam logic [AW-1:0]    LAST  = AW'(ENTRIES - 1);

    // configuration
    logic [RATE_W-1:0] r_rate_ans, r_rate_nx, r_rate_err;
    logic [WIN_W-1:0]  r_window;
    logic [SLIP_W-1:0] r_slip_every;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_ans   <= '0;
            r_rate_nx    <= '0;
            r_rate_err   <= '0;
            r_window     <= WIN_W'(15);
            r_slip_every <= SLIP_W'(2);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_RATE_ANSWERS:  r_rate_ans   <= i_cfg_data[RATE_W-1:0];
                CFG_RATE_NXDOMAIN: r_rate_nx    <= i_cfg_data[RATE_W-1:0];
                CFG_RATE_ERRORS:   r_rate_err   <= i_cfg_data[RATE_W-1:0];
                CFG_WINDOW_SECS:   r_window     <= i_cfg_data[WIN_W-1:0];
                CFG_SLIP_EVERY:    r_slip_every <= i_cfg_data[SLIP_W-1:0];
                default: ;
            endcase
        end
    end

    // capture the request, pick the rate, estimate the index quotient
    logic [RATE_W-1:0] n_rate;
    logic [QP_W-1:0]   w_qprod;
    logic [IDX_W-1:0]  r_x, r_q;
    logic [RATE_W-1:0] r_rate;
    logic              r_dis;
    logic [TIME_W-1:0] r_now;

    always_comb begin
        case (i_response_kind)
            KIND_ANSWER:   n_rate = r_rate_ans;
            KIND_NXDOMAIN: n_rate = r_rate_nx;
            KIND_ERROR:    n_rate = r_rate_err;
            default:       n_rate = '0;
        endcase
    end

    assign w_qprod = QP_W'(i_entry_index) * QP_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_en) begin
            r_x    <= i_entry_index;
            r_q    <= w_qprod[SH +: IDX_W];
            r_rate <= n_rate;
            r_dis  <= (n_rate == '0);
            r_now  <= i_now_secs;
        end
    end

    // finish the modulo: one correction step after the quotient estimate
    logic [QE_W-1:0] w_qe, w_rem, w_red;
    logic [AW-1:0]   r_addr;

    assign w_qe  = QE_W'(r_q) * QE_W'(ENT_V);
    assign w_rem = QE_W'(r_x) - w_qe;
    assign w_red = (w_rem >= QE_W'(ENT_V)) ? (w_rem - QE_W'(ENT_V)) : w_rem;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_en) begin
            r_addr <= w_red[AW-1:0];
        end
    end

    // clearing pass counter
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // entry table
    t_entry        r_mem [ENTRIES];
    t_entry        r_rd;
    t_entry        w_wdata;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_entry        w_new;

    assign w_we    = i_cmd.clr_en | (i_cmd.commit_en & ~r_dis);
    assign w_waddr = i_cmd.clr_en ? r_clr_addr : r_addr;
    assign w_wdata = i_cmd.clr_en ? '0 : w_new;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[r_addr];
    end

    // age, staleness and debt bound
    logic signed [TIME_W:0] w_age;
    logic                   r_stale, r_pos;
    logic [WIN_W-1:0]       r_age;
    logic [PROD_W-1:0]      r_lo_mag;

    assign w_age = $signed({1'b0, r_now}) - $signed({1'b0, r_rd.stamp});

    always_ff @(posedge i_clk) begin
        if (i_cmd.age_en) begin
            r_stale  <= ~r_rd.valid ||
                        (w_age > $signed({{(TIME_W+1-WIN_W){1'b0}}, r_window}));
            r_pos    <= (w_age > $signed({(TIME_W+1){1'b0}}));
            r_age    <= w_age[WIN_W-1:0];
            r_lo_mag <= PROD_W'(r_window) * PROD_W'(r_rate);
        end
    end

    // credit for elapsed seconds
    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= PROD_W'(r_rate) * PROD_W'(r_age);
        end
    end

    // refill or credit, cap at the rate, then debit one token
    logic signed [ACC_W-1:0] w_bal_ext, w_prod_ext, w_rate_ext, w_sum;
    logic signed [ACC_W-1:0] n_bal;
    logic [SLIP_W-1:0]       n_slip;
    logic signed [ACC_W-1:0] r_bal1;
    logic [SLIP_W-1:0]       r_slip;

    assign w_bal_ext  = {r_rd.bal[BAL_W-1], r_rd.bal};
    assign w_prod_ext = $signed({{(ACC_W-PROD_W){1'b0}}, r_prod});
    assign w_rate_ext = $signed({{(ACC_W-RATE_W){1'b0}}, r_rate});
    assign w_sum      = w_bal_ext + w_prod_ext;

    always_comb begin
        n_bal  = w_bal_ext;
        n_slip = r_rd.slip;
        if (r_stale) begin
            n_bal  = w_rate_ext;
            n_slip = '0;
        end else if (r_pos) begin
            if (w_sum > w_rate_ext) begin
                n_bal  = w_rate_ext;
                n_slip = '0;
            end else begin
                n_bal = w_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.credit_en) begin
            r_bal1 <= n_bal - ACC_W'(1);
            r_slip <= n_slip;
        end
    end

    // saturate the debt and decide drop or slip
    logic signed [ACC_W-1:0] w_lo, w_fin;
    logic [VERD_W-1:0]       w_verd;
    logic [SLIP_W-1:0]       w_slip_nx, w_cnt1;
    logic signed [BAL_W-1:0] w_out_bal;

    assign w_lo   = -$signed({{(ACC_W-PROD_W){1'b0}}, r_lo_mag});
    assign w_cnt1 = r_slip + SLIP_W'(1);

    always_comb begin
        w_fin     = r_bal1;
        w_verd    = VERD_SEND;
        w_slip_nx = r_slip;
        if (r_bal1 < $signed({ACC_W{1'b0}})) begin
            if (r_bal1 < w_lo) begin
                w_fin = w_lo;
            end
            w_verd = VERD_DROP;
            if (r_slip_every == SLIP_W'(1)) begin
                w_verd = VERD_SLIP;
            end else if (r_slip_every != '0) begin
                w_slip_nx = w_cnt1;
                if (r_slip == '0) begin
                    w_verd = VERD_SLIP;
                end else if (w_cnt1 >= r_slip_every) begin
                    w_slip_nx = '0;
                end
            end
        end
    end

    assign w_new.valid = 1'b1;
    assign w_new.bal   = w_fin[BAL_W-1:0];
    assign w_new.slip  = w_slip_nx;
    assign w_new.stamp = r_now;

    assign w_out_bal = r_dis ? (r_rd.valid ? r_rd.bal : '0) : w_fin[BAL_W-1:0];

    // output register
    logic                    r_out_valid;
    logic [VERD_W-1:0]       r_verdict;
    logic signed [BAL_W-1:0] r_bal_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit_en) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_en) begin
            r_verdict <= r_dis ? VERD_SEND : w_verd;
            r_bal_out <= w_out_bal;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_verdict       = r_verdict;
    assign o_balance_after = r_bal_out;

    // status
    assign o_stat.clr_last  = (r_clr_addr == LAST);
    assign o_stat.rate_zero = r_dis;
    assign o_stat.out_free  = ~r_out_valid | i_ready;

endmodule

[rtl/response_rate_limit_entry_core.sv]
// Top level of the token-bucket response rate limiter.
// Instantiates rrl_ctrl and rrl_dpath; depends on rrl_pkg.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  request | in        | i_valid / o_ready   | entry_index, response_kind, now
//  result  | out       | o_valid / i_ready   | verdict, balance_after
//  config  | in        | i_cfg_wr_en         | i_cfg_index, i_cfg_data
//
// A request passes through index reduction, table read, age, credit multiply,
// credit and commit (the multiply and credit steps are skipped when the rate
// is zero); commit loads the result, then the sequencer returns to idle.
// After reset a clearing pass marks every entry unused;
// no request is taken during it, configuration writes are.
// A result waiting in the output register does not block acceptance; the
// commit step holds only while that register is still full.
module response_rate_limit_entry_core
    import rrl_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [IDX_W-1:0]         i_entry_index,
    input  logic [KIND_W-1:0]        i_response_kind,
    input  logic [TIME_W-1:0]        i_now_secs,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [VERD_W-1:0]        o_verdict,
    output logic signed [BAL_W-1:0]  o_balance_after
);

    t_cmd  w_cmd;
    t_stat w_stat;

    rrl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_stat     (w_stat),
        .o_in_ready (o_ready),
        .o_cmd      (w_cmd)
    );

    rrl_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_entry_index   (i_entry_index),
        .i_response_kind (i_response_kind),
        .i_now_secs      (i_now_secs),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_verdict       (o_verdict),
        .o_balance_after (o_balance_after)
    );

    // no request taken while the table is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr_en |-> !o_ready)
        else $error("request accepted during clearing pass");

    // commit only into a free output register
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit_en |-> (!o_valid || i_ready))
        else $error("result committed over a pending result");

    // a new result appears only after a commit
    a_valid_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.commit_en))
        else $error("result valid without commit");

    // one request in flight: acceptance closes the input side
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second request accepted while one is in flight");

endmodule
